>>> src/brf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO with overwrite.
// ----------------------------------------------------------------------------
package brf_pkg;

	localparam int MAX_SLOTS_DEF = 256;
	localparam int LEN_W         = 9;
	localparam int DATA_W        = 8;
	localparam int COUNT_W       = 8;
	localparam int OP_W          = 2;

	localparam logic [LEN_W-1:0] RING_LEN_RESET = 9'd256;
	localparam logic [LEN_W-1:0] RING_LEN_MIN   = 9'd2;

	localparam logic [OP_W-1:0] OP_PUSH      = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH_OVER = 2'd1;
	localparam logic [OP_W-1:0] OP_POP       = 2'd2;
	localparam logic [OP_W-1:0] OP_PEEK      = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic take;
	} ctl_cmd_t;

endpackage

`default_nettype wire

>>> src/brf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_ctrl
// Handshake controller: takes a request, then holds its result until taken.
// ----------------------------------------------------------------------------
module brf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output brf_pkg::ctl_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic state_q;
	logic state_d;

	// a new request may enter in the same cycle the held result leaves
	assign in_stall  = (state_q == ST_HOLD) && out_stall;
	assign out_valid = (state_q == ST_HOLD);
	assign cmd.take  = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.take) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (!out_stall && !cmd.take) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> src/brf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_datapath
// Ring storage, read/write indices, length register and status arithmetic.
// ----------------------------------------------------------------------------
module brf_datapath #(
	parameter int MAX_SLOTS = brf_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire brf_pkg::ctl_cmd_t             cmd,
	input  wire logic                          cfg_we,
	input  wire logic [brf_pkg::LEN_W-1:0]     cfg_wdata,
	input  wire logic [brf_pkg::OP_W-1:0]      opcode,
	input  wire logic [brf_pkg::DATA_W-1:0]    write_data,
	output logic      [brf_pkg::DATA_W-1:0]    read_data,
	output logic                               failed,
	output logic      [brf_pkg::COUNT_W-1:0]   fill_count,
	output logic      [brf_pkg::COUNT_W-1:0]   free_room,
	output logic                               is_empty,
	output logic                               is_full
);

	localparam int DEPTH = (MAX_SLOTS > 256) ? 256 : MAX_SLOTS;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int LW    = brf_pkg::LEN_W;
	localparam logic [LW-1:0] LEN_TOP = LW'(DEPTH);

	logic [brf_pkg::DATA_W-1:0] mem [DEPTH];

	logic [LW-1:0]    len_q;
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] wr_q;
	logic             failed_q;
	logic             hit_q;
	logic [brf_pkg::DATA_W-1:0] rdat_q;

	logic [LW-1:0]    len_eff;
	logic [LW-1:0]    rd_inc;
	logic [LW-1:0]    wr_inc;
	logic [IDX_W-1:0] rd_nx;
	logic [IDX_W-1:0] wr_nx;
	logic             empty_now;
	logic             full_now;
	logic             mem_we;
	logic [IDX_W-1:0] rd_d;
	logic [IDX_W-1:0] wr_d;
	logic             failed_d;
	logic             hit_d;
	logic [LW-1:0]    rd9;
	logic [LW-1:0]    wr9;
	logic [LW-1:0]    fill9;
	logic [LW-1:0]    room9;

	// lengths of 0/1 act as 2, lengths past the storage act as its depth
	always_comb begin
		if (len_q < brf_pkg::RING_LEN_MIN) len_eff = brf_pkg::RING_LEN_MIN;
		else if (len_q > LEN_TOP) len_eff = LEN_TOP;
		else len_eff = len_q;
	end

	assign rd9    = LW'(rd_q);
	assign wr9    = LW'(wr_q);
	assign rd_inc = rd9 + LW'(1);
	assign wr_inc = wr9 + LW'(1);
	assign rd_nx  = (rd_inc >= len_eff) ? '0 : rd_inc[IDX_W-1:0];
	assign wr_nx  = (wr_inc >= len_eff) ? '0 : wr_inc[IDX_W-1:0];

	assign empty_now = (rd_q == wr_q);
	assign full_now  = (wr_nx == rd_q);

	always_comb begin
		rd_d     = rd_q;
		wr_d     = wr_q;
		failed_d = 1'b0;
		hit_d    = 1'b0;
		mem_we   = 1'b0;
		case (opcode)
			brf_pkg::OP_PUSH: begin
				if (full_now) begin
					failed_d = 1'b1;
				end else begin
					mem_we = 1'b1;
					wr_d   = wr_nx;
				end
			end
			brf_pkg::OP_PUSH_OVER: begin
				mem_we = 1'b1;
				wr_d   = wr_nx;
				// ring was full: oldest byte is dropped
				if (full_now) begin
					rd_d     = rd_nx;
					failed_d = 1'b1;
				end
			end
			brf_pkg::OP_POP: begin
				if (empty_now) begin
					failed_d = 1'b1;
				end else begin
					hit_d = 1'b1;
					rd_d  = rd_nx;
				end
			end
			brf_pkg::OP_PEEK: begin
				if (empty_now) failed_d = 1'b1;
				else hit_d = 1'b1;
			end
			default: failed_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take && mem_we) begin
			mem[wr_q] <= write_data;
		end
		if (cmd.take) begin
			rdat_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= brf_pkg::RING_LEN_RESET;
			rd_q     <= '0;
			wr_q     <= '0;
			failed_q <= 1'b0;
			hit_q    <= 1'b0;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
			rd_q  <= '0;
			wr_q  <= '0;
		end else if (cmd.take) begin
			rd_q     <= rd_d;
			wr_q     <= wr_d;
			failed_q <= failed_d;
			hit_q    <= hit_d;
		end
	end

	// status follows the indices, which hold while a result waits
	assign fill9 = (rd9 <= wr9) ? (wr9 - rd9) : (len_eff - (rd9 - wr9));
	assign room9 = len_eff - LW'(1) - fill9;

	assign read_data  = hit_q ? rdat_q : '0;
	assign failed     = failed_q;
	assign fill_count = fill9[brf_pkg::COUNT_W-1:0];
	assign free_room  = room9[brf_pkg::COUNT_W-1:0];
	assign is_empty   = empty_now;
	assign is_full    = full_now;

endmodule

`default_nettype wire

>>> src/byte_ring_fifo_with_overwrite.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_overwrite
// Byte circular FIFO with push, push-over, pop and peek requests.
// ----------------------------------------------------------------------------
// A request is taken while in_stall is low; its result is registered and shown
// from the next cycle on, with a new request taken in the same cycle the result
// leaves, so back-to-back requests run at one per cycle while out_stall is low.
// The single storage memory (one write and one registered read per cycle) sets
// that figure. The ring holds at most ring_length-1 bytes; ring_length below 2
// acts as 2, above min(MAX_SLOTS,256) as that value. Writing ring_length empties
// the ring and must only happen with no request in flight. There is no clearing
// pass after reset: only bytes pushed since the ring was last emptied are read.
module byte_ring_fifo_with_overwrite #(
	parameter int MAX_SLOTS = brf_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [brf_pkg::LEN_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [brf_pkg::OP_W-1:0]      opcode,
	input  wire logic [brf_pkg::DATA_W-1:0]    write_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [brf_pkg::DATA_W-1:0]    read_data,
	output logic                               failed,
	output logic      [brf_pkg::COUNT_W-1:0]   fill_count,
	output logic      [brf_pkg::COUNT_W-1:0]   free_room,
	output logic                               is_empty,
	output logic                               is_full
);

	brf_pkg::ctl_cmd_t cmd;

	brf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	brf_datapath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.opcode     (opcode),
		.write_data (write_data),
		.read_data  (read_data),
		.failed     (failed),
		.fill_count (fill_count),
		.free_room  (free_room),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

endmodule

`default_nettype wire
